>>> hdl/gmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Group mean centering package
// Register indexes, field codes and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package gmc_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 7;
  localparam int ROW_W       = 6;
  localparam int COL_W       = 6;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_COL_COUNT = CFG_INDEX_W'(1);
  localparam logic [CFG_DATA_W-1:0]  CFG_RESET     = CFG_DATA_W'(64);

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic KIND_MEAN     = 1'b0;
  localparam logic KIND_CENTERED = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

  typedef struct packed {
    logic capture;
    logic fetch_load;
    logic fetch_read;
    logic load_commit;
    logic div_start;
    logic rsp_result;
    logic rsp_nrdy;
  } gmc_cmd_t;

  typedef struct packed {
    logic load_full;
    logic div_busy;
    logic out_free;
  } gmc_stat_t;

endpackage

>>> hdl/gmc_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and its write data under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface gmc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gmc_pkg::CFG_INDEX_W-1:0] index;
  logic [gmc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/gmc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Carries a load or read request and the sample to be loaded.
// ----------------------------------------------------------------------------
interface gmc_req_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output req_type, output sample, input ready);
  modport sink   (input valid, input req_type, input sample, output ready);
endinterface

>>> hdl/gmc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Carries one row mean or centred sample, with its position and status.
// ----------------------------------------------------------------------------
interface gmc_rsp_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [SAMPLE_BITS:0]  value;
  logic [gmc_pkg::ROW_W-1:0]    row;
  logic [gmc_pkg::COL_W-1:0]    col;
  logic                         last;
  logic                         status;

  modport source (output valid, output kind, output value, output row, output col,
                  output last, output status, input ready);
  modport sink   (input valid, input kind, input value, input row, input col,
                  input last, input status, output ready);
endinterface

>>> hdl/gmc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gmc_div #(
  parameter int NW = 23,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   acc;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   den_q;
  logic [CNTW-1:0] cnt;
  logic [DW:0]     rem_sh;
  logic [DW:0]     diff;
  logic            ge;

  assign rem_sh = {rem, acc[NW-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = ~diff[DW];
  assign quo    = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNTW'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= num;
      rem   <= '0;
      den_q <= den;
      cnt   <= CNTW'(NW);
    end else if (busy) begin
      acc <= {acc[NW-2:0], ge};
      rem <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      cnt <= cnt - CNTW'(1);
    end
  end

endmodule

>>> hdl/gmc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Group mean centering datapath
// Size registers, sample and row sum memories, counters, divider and the
// result register.
// ----------------------------------------------------------------------------
module gmc_dp #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  gmc_cfg_if.sink                       cfg,
  input  logic signed [SAMPLE_BITS-1:0] req_sample,
  gmc_rsp_if.source                     rsp,
  input  gmc_pkg::gmc_cmd_t             cmd,
  output gmc_pkg::gmc_stat_t            stat
);

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CRW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS + 1);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int SW    = SAMPLE_BITS + $clog2(MAX_COLS);
  localparam int NW    = SW + 1;
  localparam int DW    = CCW + 1;
  localparam int VW    = SAMPLE_BITS + 1;

  logic [gmc_pkg::CFG_DATA_W-1:0] row_count;
  logic [gmc_pkg::CFG_DATA_W-1:0] col_count;
  logic [CRW-1:0]                 eff_rows;
  logic [CCW-1:0]                 eff_cols;
  logic [CRW+CCW-1:0]             total_full;
  logic [TW-1:0]                  total;

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SAMPLE_BITS-1:0] store_mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] store_rd;
  logic signed [SW-1:0]          sum_mem [MAX_ROWS];
  logic [MAX_ROWS-1:0]           sum_valid;
  logic signed [SW-1:0]          sum_rd;
  logic                          sum_rd_vld;
  logic signed [SW-1:0]          sum_base;
  logic [SW-1:0]                 sum_u;
  logic [SW-1:0]                 mag;
  logic [RW-1:0]                 sum_addr;

  logic [TW-1:0] load_count;
  logic [RW-1:0] load_row;
  logic          rd_phase;
  logic [RW-1:0] rd_row;
  logic [CW-1:0] rd_col;
  logic [AW-1:0] rd_addr;
  logic          rd_row_end;
  logic          rd_last;
  logic          group_clear;

  logic [NW-1:0]          div_num;
  logic [DW-1:0]          div_den;
  logic [NW-1:0]          quo;
  logic                   sum_neg;
  logic [VW-1:0]          quo_t;
  logic signed [VW-1:0]   mean;

  always_comb begin
    if (row_count == '0) begin
      eff_rows = CRW'(1);
    end else if (32'(row_count) > MAX_ROWS) begin
      eff_rows = CRW'(MAX_ROWS);
    end else begin
      eff_rows = CRW'(row_count);
    end
    if (col_count == '0) begin
      eff_cols = CCW'(1);
    end else if (32'(col_count) > MAX_COLS) begin
      eff_cols = CCW'(MAX_COLS);
    end else begin
      eff_cols = CCW'(col_count);
    end
  end

  assign total_full = (CRW+CCW)'(eff_rows) * (CRW+CCW)'(eff_cols);
  assign total      = TW'(total_full);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= gmc_pkg::CFG_RESET;
      col_count <= gmc_pkg::CFG_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == gmc_pkg::REG_ROW_COUNT) begin
        row_count <= cfg.data;
      end
      if (cfg.index == gmc_pkg::REG_COL_COUNT) begin
        col_count <= cfg.data;
      end
    end
  end

  assign rd_row_end  = CRW'(rd_row) == eff_rows - CRW'(1);
  assign rd_last     = rd_phase && (TW'(rd_addr) == total - TW'(1));
  assign group_clear = cfg.valid || (cmd.rsp_result && rd_last);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_q <= req_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_commit) begin
      store_mem[load_count[AW-1:0]] <= sample_q;
    end
    if (cmd.fetch_read) begin
      store_rd <= store_mem[rd_addr];
    end
  end

  assign sum_addr = cmd.fetch_read ? rd_row : load_row;
  assign sum_base = sum_rd_vld ? sum_rd : '0;

  always_ff @(posedge clk) begin
    if (cmd.load_commit) begin
      sum_mem[load_row] <= sum_base + SW'(sample_q);
    end
    if (cmd.fetch_load || cmd.fetch_read) begin
      sum_rd     <= sum_mem[sum_addr];
      sum_rd_vld <= sum_valid[sum_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || group_clear) begin
      sum_valid <= '0;
    end else if (cmd.load_commit) begin
      sum_valid[load_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || group_clear) begin
      load_count <= '0;
      load_row   <= '0;
    end else if (cmd.load_commit) begin
      load_count <= load_count + TW'(1);
      if (CRW'(load_row) == eff_rows - CRW'(1)) begin
        load_row <= '0;
      end else begin
        load_row <= load_row + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || group_clear) begin
      rd_phase <= 1'b0;
      rd_row   <= '0;
      rd_col   <= '0;
      rd_addr  <= '0;
    end else if (cmd.rsp_result) begin
      if (!rd_phase) begin
        if (rd_row_end) begin
          rd_phase <= 1'b1;
          rd_row   <= '0;
          rd_col   <= '0;
          rd_addr  <= '0;
        end else begin
          rd_row <= rd_row + RW'(1);
        end
      end else begin
        rd_addr <= rd_addr + AW'(1);
        if (rd_row_end) begin
          rd_row <= '0;
          rd_col <= rd_col + CW'(1);
        end else begin
          rd_row <= rd_row + RW'(1);
        end
      end
    end
  end

  assign sum_u   = sum_base;
  assign mag     = sum_u[SW-1] ? (SW'(0) - sum_u) : sum_u;
  assign div_num = {mag, 1'b0} + NW'(eff_cols);
  assign div_den = {eff_cols, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      sum_neg <= sum_base[SW-1];
    end
  end

  gmc_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (stat.div_busy),
    .quo   (quo)
  );

  assign quo_t = VW'(quo);
  assign mean  = sum_neg ? (VW'(0) - quo_t) : quo_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.rsp_result || cmd.rsp_nrdy) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rsp_result) begin
      rsp.kind   <= rd_phase ? gmc_pkg::KIND_CENTERED : gmc_pkg::KIND_MEAN;
      rsp.value  <= rd_phase ? (VW'(store_rd) - mean) : mean;
      rsp.row    <= gmc_pkg::ROW_W'(rd_row);
      rsp.col    <= rd_phase ? gmc_pkg::COL_W'(rd_col) : '0;
      rsp.last   <= rd_last;
      rsp.status <= gmc_pkg::STATUS_OK;
    end else if (cmd.rsp_nrdy) begin
      rsp.kind   <= gmc_pkg::KIND_MEAN;
      rsp.value  <= '0;
      rsp.row    <= '0;
      rsp.col    <= '0;
      rsp.last   <= 1'b0;
      rsp.status <= gmc_pkg::STATUS_NOT_READY;
    end
  end

  assign stat.load_full = load_count == total;
  assign stat.out_free  = !rsp.valid || rsp.ready;

endmodule

>>> hdl/gmc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Group mean centering controller
// Sequences loads and reads through the datapath, one request at a time.
// ----------------------------------------------------------------------------
module gmc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_type,
  output logic               req_ready,
  input  gmc_pkg::gmc_stat_t stat,
  output gmc_pkg::gmc_cmd_t  cmd
);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_LD_RD    = 7'b0000010,
    ST_LD_WR    = 7'b0000100,
    ST_RD_FETCH = 7'b0001000,
    ST_RD_START = 7'b0010000,
    ST_RD_DIV   = 7'b0100000,
    ST_RD_OUT   = 7'b1000000
  } state_t;

  // The not-ready reply reuses the output state with no division behind it.
  state_t state;
  state_t state_next;
  logic   nrdy;
  logic   nrdy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      nrdy  <= 1'b0;
    end else begin
      state <= state_next;
      nrdy  <= nrdy_next;
    end
  end

  always_comb begin
    state_next = state;
    nrdy_next  = nrdy;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          if (req_type == gmc_pkg::REQ_LOAD) begin
            if (!stat.load_full) begin
              state_next = ST_LD_RD;
            end
          end else if (stat.load_full) begin
            state_next = ST_RD_FETCH;
          end else begin
            nrdy_next  = 1'b1;
            state_next = ST_RD_OUT;
          end
        end
      end
      ST_LD_RD: begin
        cmd.fetch_load = 1'b1;
        state_next     = ST_LD_WR;
      end
      ST_LD_WR: begin
        cmd.load_commit = 1'b1;
        state_next      = ST_IDLE;
      end
      ST_RD_FETCH: begin
        cmd.fetch_read = 1'b1;
        state_next     = ST_RD_START;
      end
      ST_RD_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_RD_DIV;
      end
      ST_RD_DIV: begin
        if (!stat.div_busy) begin
          state_next = ST_RD_OUT;
        end
      end
      ST_RD_OUT: begin
        if (stat.out_free) begin
          cmd.rsp_result = !nrdy;
          cmd.rsp_nrdy   = nrdy;
          nrdy_next      = 1'b0;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        nrdy_next  = 1'b0;
      end
    endcase
  end

endmodule

>>> hdl/group_mean_centering_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Group mean centering unit
// Loads a group of samples, then reads out the row means and every sample
// with its row mean removed.
// ----------------------------------------------------------------------------
// The block handles one transaction at a time. A load captures the sample, reads
// the running sum of the sample's row from its memory, then writes the sum and
// the sample back. A read that finds loading incomplete goes straight to the
// output state and answers not ready. A read of a mean or centred sample waits
// for the restoring divider that forms the rounded row mean one quotient bit
// per cycle. A read waits longer while the previous result has not been taken.
// Row sums are cleared at once through per-row valid bits, so no clearing pass
// follows reset or a register write.
module group_mean_centering_unit #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  gmc_cfg_if.sink   cfg,
  gmc_req_if.sink   req,
  gmc_rsp_if.source rsp
);

  gmc_pkg::gmc_cmd_t  cmd;
  gmc_pkg::gmc_stat_t stat;

  gmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gmc_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .req_sample (req.sample),
    .rsp        (rsp),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

>>> hdl/gmc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Group mean centering checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module gmc_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic                       rsp_kind,
  input logic [SAMPLE_BITS:0]       rsp_value,
  input logic [gmc_pkg::ROW_W-1:0]  rsp_row,
  input logic [gmc_pkg::COL_W-1:0]  rsp_col,
  input logic                       rsp_last,
  input logic                       rsp_status
);

  // A result that is not taken stays put.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_row)
      && $stable(rsp_col) && $stable(rsp_last) && $stable(rsp_kind))
    else $error("Result changed while stalled.");

  // A not-ready reply carries nothing else.
  a_nrdy_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == gmc_pkg::STATUS_NOT_READY |->
      rsp_kind == gmc_pkg::KIND_MEAN && rsp_value == '0 && rsp_row == '0
      && rsp_col == '0 && !rsp_last)
    else $error("Not-ready reply has non-zero fields.");

  // A row mean has no column and never ends the readout.
  a_mean_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == gmc_pkg::STATUS_OK && rsp_kind == gmc_pkg::KIND_MEAN
      |-> rsp_col == '0 && !rsp_last)
    else $error("Row mean has a column or ends the readout.");

  // After the final result of a readout the next result opens a new group.
  a_after_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && rsp_last ##1 rsp_valid && rsp_status == gmc_pkg::STATUS_OK
      |-> rsp_kind == gmc_pkg::KIND_MEAN && rsp_row == '0)
    else $error("Readout did not restart after the final result.");

endmodule

bind group_mean_centering_unit gmc_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_gmc_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_kind   (rsp.kind),
  .rsp_value  (rsp.value),
  .rsp_row    (rsp.row),
  .rsp_col    (rsp.col),
  .rsp_last   (rsp.last),
  .rsp_status (rsp.status)
);
